// ===== rtl/sfdd_pkg.sv =====
package sfdd_pkg;

    localparam int HALF_W  = 64;
    localparam int VALUE_W = 2 * HALF_W;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    // double-dabble correction: a digit of five or more gets three added before the shift
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;

    // what every digit cell does on each clock edge
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/sfdd_ifs.sv =====
interface sfdd_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sfdd_pkg::HALF_W-1:0]     value_high;
    logic        [sfdd_pkg::HALF_W-1:0]     value_low;

    modport source (output valid, output value_high, output value_low, input ready);
    modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface sfdd_out_if;
    logic                           valid;
    logic                           ready;
    logic [sfdd_pkg::CHAR_W-1:0]    out_char;
    logic                           last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== rtl/sfdd_cell.sv =====
module sfdd_cell (
    input  logic                            clk,
    input  sfdd_pkg::cell_ctrl_t            ctrl,
    input  logic                            bit_in,
    input  logic [sfdd_pkg::DIGIT_W-1:0]    digit_in,
    output logic                            bit_out,
    output logic [sfdd_pkg::DIGIT_W-1:0]    digit
);

    logic [sfdd_pkg::DIGIT_W-1:0] digit_reg;
    logic [sfdd_pkg::DIGIT_W-1:0] digit_next;
    logic [sfdd_pkg::DIGIT_W-1:0] adj;

    // add-3 correction, then the msb moves on to the next cell
    assign adj     = (digit_reg >= sfdd_pkg::DABBLE_LIMIT) ?
                     digit_reg + sfdd_pkg::DABBLE_ADD : digit_reg;
    assign bit_out = adj[sfdd_pkg::DIGIT_W-1];
    assign digit   = digit_reg;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[sfdd_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== rtl/sfdd_chain.sv =====
module sfdd_chain #(
    parameter int NUM_DIGITS = 36
) (
    input  logic                            clk,
    input  sfdd_pkg::cell_ctrl_t            ctrl,
    input  logic                            bit_in,
    output logic                            carry_out,
    output logic [sfdd_pkg::DIGIT_W-1:0]    top_digit
);

    logic [NUM_DIGITS-1:0]              bits;
    logic [sfdd_pkg::DIGIT_W-1:0]       digits [NUM_DIGITS];

    // cell 0 is the least significant digit; data moves towards the top
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        logic                           cell_bit_in;
        logic [sfdd_pkg::DIGIT_W-1:0]   cell_digit_in;

        if (i == 0)
        begin : g_first
            assign cell_bit_in   = bit_in;
            assign cell_digit_in = '0;
        end
        else
        begin : g_rest
            assign cell_bit_in   = bits[i-1];
            assign cell_digit_in = digits[i-1];
        end

        sfdd_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .bit_in   (cell_bit_in),
            .digit_in (cell_digit_in),
            .bit_out  (bits[i]),
            .digit    (digits[i])
        );
    end

    assign carry_out = bits[NUM_DIGITS-1];
    assign top_digit = digits[NUM_DIGITS-1];

endmodule

// ===== rtl/signed_fixed_to_decimal_digits_unit.sv =====
// flow: an accepted value is converted msb first (S_CONV), leading zeros are stripped (S_SKIP),
//   then a minus sign for a negative value (S_SIGN) and the digits (S_EMIT) are registered
// input: one value at a time; stripped zeros plus sent digits make MAX_DIGITS, and the next
//   beat is taken only once the last character is registered; sink stalls hold S_SIGN and S_EMIT
// reset: rst_n clears the sequencer and the output valid at once; digit cells need no reset
module signed_fixed_to_decimal_digits_unit #(
    parameter int FRACTION_BITS = 8,
    parameter int MAX_DIGITS    = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    sfdd_in_if.sink             value_ch,
    sfdd_out_if.source          text_ch
);

    // integer magnitude width once the fraction is dropped
    localparam int MAG_W  = sfdd_pkg::VALUE_W - FRACTION_BITS;
    localparam int BCNT_W = $clog2(MAG_W + 1);
    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                             state_reg, state_next;
    logic [MAG_W-1:0]                   mag_reg, mag_next;
    logic                               neg_reg, neg_next;
    logic                               ovf_reg, ovf_next;
    logic [BCNT_W-1:0]                  bit_cnt_reg, bit_cnt_next;
    logic [DCNT_W-1:0]                  dig_cnt_reg, dig_cnt_next;
    logic                               out_valid_reg, out_valid_next;
    logic [sfdd_pkg::CHAR_W-1:0]        out_char_reg, out_char_next;
    logic                               out_last_reg, out_last_next;

    sfdd_pkg::cell_ctrl_t               ctrl;
    logic                               carry_out;
    logic [sfdd_pkg::DIGIT_W-1:0]       top_digit;

    logic                               in_beat;
    logic                               emit_ok;
    logic [sfdd_pkg::VALUE_W-1:0]       full_value;
    logic [sfdd_pkg::VALUE_W-1:0]       abs_value;
    logic [sfdd_pkg::CHAR_W-1:0]        digit_char;

    assign value_ch.ready = (state_reg == S_IDLE);
    assign in_beat        = value_ch.valid && value_ch.ready;

    // output register is free, or its beat leaves this cycle
    assign emit_ok = !out_valid_reg || text_ch.ready;

    assign text_ch.valid     = out_valid_reg;
    assign text_ch.out_char  = out_char_reg;
    assign text_ch.last_char = out_last_reg;

    // magnitude of the two's-complement value; the most negative value maps onto itself,
    // which read unsigned is exactly its magnitude
    assign full_value = {value_ch.value_high, value_ch.value_low};
    assign abs_value  = full_value[sfdd_pkg::VALUE_W-1] ? (~full_value + 1'b1) : full_value;

    assign digit_char = sfdd_pkg::ASCII_ZERO +
                        {{(sfdd_pkg::CHAR_W - sfdd_pkg::DIGIT_W){1'b0}}, top_digit};

    sfdd_chain #(
        .NUM_DIGITS (MAX_DIGITS)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (mag_reg[MAG_W-1]),
        .carry_out (carry_out),
        .top_digit (top_digit)
    );

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        ovf_next       = ovf_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg && !text_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    ctrl.clear   = 1'b1;
                    mag_next     = abs_value[sfdd_pkg::VALUE_W-1:FRACTION_BITS];
                    neg_next     = full_value[sfdd_pkg::VALUE_W-1];
                    ovf_next     = 1'b0;
                    bit_cnt_next = BCNT_W'(MAG_W);
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                // one magnitude bit enters the chain per cycle, msb first; a carry falling
                // off the top digit means the text is wider than the chain
                ctrl.dabble  = 1'b1;
                mag_next     = {mag_reg[MAG_W-2:0], 1'b0};
                ovf_next     = ovf_reg || carry_out;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BCNT_W'(1))
                begin
                    dig_cnt_next = DCNT_W'(MAX_DIGITS);
                    state_next   = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // strip leading zeros, keeping at least one digit; a wrapped text keeps all
                if (!ovf_reg && top_digit == '0 && dig_cnt_reg != DCNT_W'(1))
                begin
                    ctrl.shift   = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sfdd_pkg::ASCII_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    ctrl.shift     = 1'b1;
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char;
                    out_last_next  = (dig_cnt_reg == DCNT_W'(1));
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DCNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        ovf_reg      <= ovf_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // an accepted value always starts the conversion
    a_beat_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> state_reg == S_CONV)
        else $error("accepted value did not start conversion");

    // the bit counter never runs out while bits are still being shifted in
    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CONV |-> bit_cnt_reg != '0)
        else $error("conversion with empty bit count");

    // digits remain whenever a digit is about to be sent
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> dig_cnt_reg != '0)
        else $error("digit emission with empty digit count");

    // a minus sign is only ever produced for a negative value
    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SIGN |-> neg_reg)
        else $error("sign state for a non-negative value");

    // the last character of a value returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && emit_ok && dig_cnt_reg == DCNT_W'(1)) |=>
        (state_reg == S_IDLE && out_last_reg))
        else $error("last character did not end the value");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int FRACTION_BITS  = 8;
    localparam int MAX_DIGITS     = 36;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    // conversion, leading-zero strip and a full line of characters, with room to spare
    localparam int SETTLE_CYCLES  = 250;
    // longest quiet spell a correct run can show: a wide sender gap plus a whole
    // conversion, or a receiver stall on one character
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 40;

    // one character beat of the decimal text
    typedef struct packed {
        logic [sfdd_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_beat_t;

    logic clk;
    logic rst_n;

    sfdd_in_if  value_ch ();
    sfdd_out_if text_ch ();

    signed_fixed_to_decimal_digits_unit #(
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_DIGITS    (MAX_DIGITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch),
        .text_ch  (text_ch)
    );

    // characters still owed by the block, oldest first
    text_beat_t expected_text[$];
    int         error_count;
    int         burst_left;
    int         quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // text predictor: magnitude, drop the fraction, then divide by ten
    // until nothing is left or the digit budget runs out
    // ------------------------------------------------------------------
    task automatic predict_text(input logic [sfdd_pkg::VALUE_W-1:0] value);
        logic [sfdd_pkg::VALUE_W-1:0] magnitude;
        logic [sfdd_pkg::VALUE_W-1:0] remainder;
        logic [sfdd_pkg::DIGIT_W-1:0] digits [MAX_DIGITS];
        logic                         negative;
        int                           count;
        text_beat_t                   beat;

        negative  = value[sfdd_pkg::VALUE_W-1];
        // two's-complement negate; the most negative value wraps to 2^127 unsigned
        magnitude = negative ? (~value + 1'b1) : value;
        magnitude = magnitude >> FRACTION_BITS;
        count     = 0;
        do
        begin
            remainder     = magnitude % 10;
            digits[count] = remainder[sfdd_pkg::DIGIT_W-1:0];
            magnitude     = magnitude / 10;
            count++;
        end
        while (magnitude != 0 && count < MAX_DIGITS);

        if (negative)
        begin
            beat.ch   = sfdd_pkg::ASCII_MINUS;
            beat.last = 1'b0;
            expected_text.push_back(beat);
        end
        for (int k = count - 1; k >= 0; k--)
        begin
            beat.ch   = sfdd_pkg::ASCII_ZERO + sfdd_pkg::CHAR_W'(digits[k]);
            beat.last = (k == 0);
            expected_text.push_back(beat);
        end
    endtask

    // builds a fixed-point value from an integer magnitude, a fraction and a sign
    function automatic logic [sfdd_pkg::VALUE_W-1:0] fixed_value(
        input logic [sfdd_pkg::VALUE_W-1:0] whole,
        input logic [sfdd_pkg::VALUE_W-1:0] frac,
        input logic                         negative);
        logic [sfdd_pkg::VALUE_W-1:0] raw;
        raw = (whole << FRACTION_BITS) | (frac & ((128'd1 << FRACTION_BITS) - 128'd1));
        return negative ? (~raw + 1'b1) : raw;
    endfunction

    function automatic logic [sfdd_pkg::VALUE_W-1:0] pow10(input int exponent);
        logic [sfdd_pkg::VALUE_W-1:0] p;
        p = 128'd1;
        repeat (exponent) p = p * 128'd10;
        return p;
    endfunction

    function automatic logic [sfdd_pkg::VALUE_W-1:0] random_word();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of back-to-back beats broken by gaps of random length;
    // a wide gap lets the next beat land anywhere in the block's conversion
    // ------------------------------------------------------------------
    task automatic send_value(input logic [sfdd_pkg::VALUE_W-1:0] value);
        int gap;

        if (burst_left == 0)
        begin
            value_ch.valid <= 1'b0;
            case ($urandom_range(0, 2))
                0:       gap = $urandom_range(1, 4);
                1:       gap = $urandom_range(1, 260);
                default: gap = 1;
            endcase
            repeat (gap) @(posedge clk);
            // mostly short bursts, now and then a long one with no idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        value_ch.valid      <= 1'b1;
        value_ch.value_high <= value[sfdd_pkg::VALUE_W-1:sfdd_pkg::HALF_W];
        value_ch.value_low  <= value[sfdd_pkg::HALF_W-1:0];
        do
            @(posedge clk);
        while (!value_ch.ready);
        // beat taken at this edge: what it will print is now owed
        predict_text(value);
        burst_left--;
    endtask

    // hold the sender off until the block has printed everything it owes
    task automatic wait_for_text_drained();
        value_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (expected_text.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero, sub-unit values of both signs, decade edges and the range ends
    task automatic test_directed();
        send_value('0);
        send_value(fixed_value(128'd0, 128'h80, 1'b0));      // one half prints 0
        send_value(fixed_value(128'd0, 128'h80, 1'b1));      // minus one half prints -0
        send_value({sfdd_pkg::VALUE_W{1'b1}});               // smallest step below zero
        send_value(fixed_value(128'd1, 128'd0, 1'b0));
        send_value(fixed_value(128'd1, 128'd0, 1'b1));
        send_value(fixed_value(128'd9, 128'hff, 1'b0));      // truncation, never rounding
        send_value(fixed_value(128'd10, 128'd0, 1'b0));
        send_value(fixed_value(128'd10, 128'h01, 1'b1));
        send_value({1'b0, {(sfdd_pkg::VALUE_W-1){1'b1}}});   // largest positive
        send_value({1'b1, {(sfdd_pkg::VALUE_W-1){1'b0}}});   // most negative: 2^119 in full
        send_value({1'b1, {(sfdd_pkg::VALUE_W-2){1'b0}}, 1'b1}); // one above most negative
        send_value(fixed_value(pow10(35), 128'd0, 1'b0));    // widest decimal length
        send_value(fixed_value(pow10(35) - 128'd1, 128'hff, 1'b1));
        send_value({64'h1, 64'h0});                          // carry across the halves
        send_value({64'h0, 64'hffff_ffff_ffff_ff00});
        send_value({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
        send_value({64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
        send_value(fixed_value(128'd12345678901234567890, 128'h7f, 1'b1));
        send_value(fixed_value(pow10(19), 128'h00, 1'b1));
    endtask

    // full-width random patterns: every bit of both halves toggles, most give 36 digits
    task automatic test_random_patterns(input int count);
        repeat (count) send_value(random_word());
    endtask

    // magnitudes of random bit length, so every text length turns up
    task automatic test_random_lengths(input int count);
        int                           width;
        logic [sfdd_pkg::VALUE_W-1:0] raw;

        repeat (count)
        begin
            width = $urandom_range(1, sfdd_pkg::VALUE_W - 1);
            raw   = random_word() & ((128'd1 << width) - 128'd1);
            send_value($urandom_range(0, 1) ? (~raw + 1'b1) : raw);
        end
    endtask

    // just below, on and just above powers of ten, where the digit count steps
    task automatic test_decade_edges(input int count);
        logic [sfdd_pkg::VALUE_W-1:0] whole;

        repeat (count)
        begin
            whole = pow10($urandom_range(0, 35));
            case ($urandom_range(0, 2))
                0:       whole = whole - 128'd1;
                1:       whole = whole + 128'd1;
                default: ;
            endcase
            send_value(fixed_value(whole, 128'($urandom), 1'($urandom_range(0, 1))));
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: stalls on a pattern of its own, switching between always
    // ready, coin-flip, periodic and long stalls every so often
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int hold;
        int phase;

        text_ch.ready = 1'b0;
        phase         = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            hold = $urandom_range(20, 200);
            repeat (hold)
            begin
                @(posedge clk);
                phase++;
                case (mode)
                    0:       text_ch.ready <= 1'b1;
                    1:       text_ch.ready <= 1'($urandom_range(0, 1));
                    2:       text_ch.ready <= (phase % 5) != 4;
                    default: text_ch.ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // checker: each character beat against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_text
        text_beat_t want;

        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            if (expected_text.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected character beat, expected none, actual %0d last %0b",
                             $time, text_ch.out_char, text_ch.last_char);
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_ch.out_char !== want.ch)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: out_char mismatch, expected %0d, actual %0d",
                                 $time, want.ch, text_ch.out_char);
                end
                if (text_ch.last_char !== want.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: last_char mismatch, expected %0b, actual %0b",
                                 $time, want.last, text_ch.last_char);
                end
            end
        end
    end

    // watchdog: too long without a beat on either side ends the run
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((value_ch.valid && value_ch.ready) || (text_ch.valid && text_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[signed_fixed_to_decimal_digits_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        error_count         = 0;
        burst_left          = 0;
        rst_n               = 1'b0;
        value_ch.valid      = 1'b0;
        value_ch.value_high = '0;
        value_ch.value_low  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // the sender waits here for every owed character before going on
        wait_for_text_drained();
        test_random_patterns(200);
        test_decade_edges(120);
        wait_for_text_drained();
        test_random_lengths(160);

        // all beats sent: let the block finish printing, then allow some slack
        value_ch.valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[signed_fixed_to_decimal_digits_unit] OK");
        else
            $display("[signed_fixed_to_decimal_digits_unit] ERROR");
        $finish;
    end

endmodule
